### src/psta_pkg.sv
// Package for the pi series term accumulator: widths, constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
package psta_pkg;

    localparam int ACC_BITS_DEF    = 192;
    localparam int DIGIT_COUNT_DEF = 12;
    localparam int MOD_W           = 64;
    localparam int EXP_W           = 35;
    localparam int FIVE_W          = 32;
    localparam int DIG_W           = 40;
    localparam int TOP_W           = 64;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_POWER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_CUTOFF = 1'b1;

    localparam logic [FIVE_W-1:0] FIVE_POWER_RST = 32'd999999;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_LOAD     = 4'd0,  // latch request, clear accumulator on restart
        OP_POW_INIT = 4'd1,  // start a power: result 1, base and exponent set
        OP_POW_SQ   = 4'd2,  // one step of the base squaring, shift exponent at the end
        OP_POW_ML   = 4'd3,  // one step of the result times base
        OP_POW_SHR  = 4'd4,  // finish a power, keep it as first factor when asked
        OP_COMBINE  = 4'd5,  // one step of residue times saved power
        OP_DIV      = 4'd6,  // one quotient bit of r * 2^ACC / mu
        OP_ACCUM    = 4'd7,  // add or subtract quotient
        OP_DIGITS   = 4'd8,  // one shift-add step of acc * 10^D
        OP_NONE     = 4'd9
    } t_op;

    // Which power is being formed
    typedef enum logic [1:0] {
        PW_FIVE = 2'd0,
        PW_TWO  = 2'd1,
        PW_HALF = 2'd2
    } t_pw;

    typedef struct packed {
        t_op  op;
        t_pw  pw;
        logic save_first;   // keep finished power as the first factor
        logic mul_first;    // the pending multiply step is the first, which loads the operands
    } t_cmd;

    typedef struct packed {
        logic mm_done;      // modular multiply finished its 64 steps
        logic exp_zero;     // power exponent exhausted
        logic exp_bit;      // low exponent bit
        logic active;       // term contributes
        logic neg_exp;      // latched exponent is negative
        logic div_done;     // last quotient bit this cycle
        logic dig_done;     // last digit step this cycle
    } t_sts;

endpackage

### src/psta_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface psta_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pi_series_term_accumulator.sv
// Top level of the pi series term accumulator: config registers, channels.
// Depends on psta_pkg, psta_if, psta_ctrl, psta_datapath.
//
// Usage: write five_power (index 0) and band_cutoff (index 1) on the config
// port while idle. Each input request carries {restart, negate, two_exponent,
// modulus}; each gives exactly one output request {digits, acc_top}.
// Each request forms the power of five and the power of two (or of one half),
// both on the bit-serial modular multiply shared by the powers and the combine,
// then combines them and runs the restoring division and the digit shift-add.
// A term that contributes nothing skips the powers, the combine and the division.
// One request is worked on at a time, and the next is taken only after the
// result is accepted.
// Reset clears the accumulator, sets five_power to 999999 and band_cutoff to 0.
// A stalled receiver holds the result; no new request is taken until it leaves.
`timescale 1ns / 1ps
module pi_series_term_accumulator
    import psta_pkg::*;
#(
    parameter int ACC_BITS    = ACC_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    psta_if.sink                  in_ch,
    psta_if.source                out_ch
);
    logic [FIVE_W-1:0] r_five_power;
    logic [EXP_W-1:0]  r_band_cutoff;
    t_cmd cmd;
    t_sts sts;
    logic [DIG_W-1:0] digits;
    logic [TOP_W-1:0] acc_top;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_five_power  <= FIVE_POWER_RST;
            r_band_cutoff <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIVE_POWER:  r_five_power  <= i_cfg_data[FIVE_W-1:0];
                CFG_BAND_CUTOFF: r_band_cutoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psta_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (in_ch.valid), .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    psta_datapath #(.ACC_BITS(ACC_BITS), .DIGIT_COUNT(DIGIT_COUNT)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_restart     (in_ch.data[MOD_W+EXP_W+1]),
        .i_negate      (in_ch.data[MOD_W+EXP_W]),
        .i_two_exponent(in_ch.data[MOD_W+EXP_W-1:MOD_W]),
        .i_modulus     (in_ch.data[MOD_W-1:0]),
        .i_five_power  (r_five_power),
        .i_band_cutoff (r_band_cutoff),
        .o_digits(digits), .o_acc_top(acc_top)
    );

    assign out_ch.data = {digits, acc_top};
endmodule

### src/psta_datapath.sv
// Datapath: modular powers, scaled quotient, accumulator and digit readout.
// Depends on psta_pkg.
`timescale 1ns / 1ps
module psta_datapath
    import psta_pkg::*;
#(
    parameter int ACC_BITS    = ACC_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_restart,
    input  logic              i_negate,
    input  logic [EXP_W-1:0]  i_two_exponent,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic [FIVE_W-1:0] i_five_power,
    input  logic [EXP_W-1:0]  i_band_cutoff,
    output logic [DIG_W-1:0]  o_digits,
    output logic [TOP_W-1:0]  o_acc_top
);
    localparam int CNT_W = $clog2(ACC_BITS + 1);
    // 10^D fits in 64 bits for D up to 19
    localparam int TEN_W = 64;
    localparam int PROD_W = ACC_BITS + TEN_W;

    function automatic logic [TEN_W-1:0] ten_pow(input int d);
        logic [TEN_W-1:0] p;
        p = 64'd1;
        for (int k = 0; k < d; k++) p = p * 64'd10;
        return p;
    endfunction
    localparam logic [TEN_W-1:0] TEN_D = ten_pow(DIGIT_COUNT);

    // Request registers
    logic              r_negate;
    logic [EXP_W-1:0]  r_exp;
    logic [MOD_W-1:0]  r_mu;
    logic              r_active;
    // Power state
    logic [MOD_W-1:0]  r_base, r_res, r_first, r_mres, r_mb;
    logic [EXP_W-1:0]  r_pexp;
    logic [6:0]        r_mcnt;
    // Quotient and accumulator
    logic [MOD_W-1:0]  r_rem;
    logic              r_rem_nz;
    logic [ACC_BITS-1:0] r_quo, r_acc;
    logic [CNT_W-1:0]  r_cnt;
    // Digit readout
    logic [PROD_W-1:0] r_prod;
    logic [TEN_W-1:0]  r_mult;

    logic              neg_exp;
    logic [EXP_W-1:0]  mag;
    logic [MOD_W-1:0]  half, mul_a;
    logic [MOD_W:0]    dbl, dsum;
    logic [MOD_W-1:0]  step_dbl, step_add, mm_next;
    logic              mbit;
    logic [MOD_W:0]    rdbl;
    logic [ACC_BITS-1:0] acc_next;

    assign neg_exp = r_exp[EXP_W-1];
    assign mag     = (~r_exp) + {{(EXP_W-1){1'b0}}, 1'b1};
    assign half    = (r_mu >> 1) + {{(MOD_W-1){1'b0}}, r_mu[0]};

    // One double-and-add step of the bit-serial modular multiply (mres*2 + a*bit)
    assign mul_a = (i_cmd.op == OP_POW_SQ) ? r_base :
                   (i_cmd.op == OP_POW_ML) ? r_base : r_first;
    assign mbit  = r_mb[MOD_W-1];
    always_comb begin
        dbl      = {1'b0, r_mres} + {1'b0, r_mres};
        step_dbl = (dbl >= {1'b0, r_mu}) ? 64'(dbl - {1'b0, r_mu}) : dbl[MOD_W-1:0];
        dsum     = {1'b0, step_dbl} + {1'b0, mul_a};
        step_add = (dsum >= {1'b0, r_mu}) ? 64'(dsum - {1'b0, r_mu}) : dsum[MOD_W-1:0];
        mm_next  = mbit ? step_add : step_dbl;
    end

    assign rdbl = {r_rem, 1'b0};

    // Term applied to the accumulator, wrapping at its width
    always_comb begin
        acc_next = r_acc;
        if (r_active && r_rem_nz) acc_next = r_negate ? r_acc - r_quo : r_acc + r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_active <= 1'b0;
            r_mcnt   <= '0;
            r_cnt    <= '0;
        end else begin
            unique case (i_cmd.op)
                // Latch request, decide whether the term counts
                OP_LOAD: begin
                    r_negate <= i_negate;
                    r_exp    <= i_two_exponent;
                    r_mu     <= i_modulus;
                    if (i_restart) r_acc <= '0;
                    r_active <= (i_modulus > 64'd1) &&
                                (!i_two_exponent[EXP_W-1] ||
                                 (((~i_two_exponent) + 35'd1) < i_band_cutoff));
                end
                // Prepare a power: base reduced modulo mu (mu is at least two here)
                OP_POW_INIT: begin
                    r_res <= 64'd1;
                    unique case (i_cmd.pw)
                        PW_FIVE: begin
                            if (r_mu > 64'd5)       r_base <= 64'd5;
                            else if (r_mu == 64'd5) r_base <= 64'd0;
                            else if (r_mu == 64'd3) r_base <= 64'd2;
                            else                    r_base <= 64'd1;
                            r_pexp <= {3'b000, i_five_power};
                        end
                        PW_TWO: begin
                            r_base <= (r_mu > 64'd2) ? 64'd2 : 64'd0;
                            r_pexp <= r_exp;
                        end
                        default: begin
                            r_base <= (half >= r_mu) ? half - r_mu : half;
                            r_pexp <= mag;
                        end
                    endcase
                end
                // Bit-serial multiply steps: squaring, result times base, combine
                OP_POW_SQ, OP_POW_ML, OP_COMBINE: begin
                    if (i_cmd.mul_first) begin
                        r_mres <= '0;
                        r_mb   <= (i_cmd.op == OP_POW_SQ) ? r_base :
                                  (i_cmd.op == OP_POW_ML) ? r_res : r_res;
                        r_mcnt <= '0;
                    end else begin
                        r_mres <= mm_next;
                        r_mb   <= r_mb << 1;
                        r_mcnt <= r_mcnt + 7'd1;
                        if (r_mcnt == 7'd63) begin
                            // Squaring done: advance to the next exponent bit
                            if (i_cmd.op == OP_POW_SQ) begin
                                r_base <= mm_next;
                                r_pexp <= r_pexp >> 1;
                            end else begin
                                r_res <= mm_next;
                            end
                            r_rem <= mm_next;
                            r_cnt <= '0;
                        end
                    end
                end
                // Finish a power; keep it as the first factor when asked
                OP_POW_SHR: begin
                    if (i_cmd.save_first) r_first <= r_res;
                end
                // One restoring-division bit of r * 2^ACC / mu
                OP_DIV: begin
                    if (rdbl >= {1'b0, r_mu}) begin
                        r_rem <= 64'(rdbl - {1'b0, r_mu});
                        r_quo <= {r_quo[ACC_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rdbl[MOD_W-1:0];
                        r_quo <= {r_quo[ACC_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                // Apply the term and seed the digit readout
                OP_ACCUM: begin
                    r_acc  <= acc_next;
                    r_prod <= '0;
                    r_mult <= TEN_D;
                    r_cnt  <= '0;
                end
                // Shift-add multiply of acc by 10^D, one multiplier bit a cycle
                OP_DIGITS: begin
                    if (r_mult[TEN_W-1])
                        r_prod <= (r_prod << 1) + {{TEN_W{1'b0}}, r_acc};
                    else
                        r_prod <= r_prod << 1;
                    r_mult <= r_mult << 1;
                    r_cnt  <= r_cnt + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Nonzero flag of the residue, held for the whole divide; captured before it starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_rem_nz <= 1'b0;
        else if (i_cmd.op == OP_COMBINE && !i_cmd.mul_first && r_mcnt == 7'd63)
            r_rem_nz <= (mm_next != '0);
    end

    assign o_sts.mm_done  = (r_mcnt == 7'd63);
    assign o_sts.exp_zero = (r_pexp == '0);
    assign o_sts.exp_bit  = r_pexp[0];
    assign o_sts.active   = r_active;
    assign o_sts.neg_exp  = neg_exp;
    assign o_sts.div_done = (r_cnt == CNT_W'(ACC_BITS - 1));
    assign o_sts.dig_done = (r_cnt == CNT_W'(TEN_W - 1));

    assign o_digits  = DIG_W'(r_prod >> ACC_BITS);
    assign o_acc_top = r_acc[ACC_BITS-1 -: TOP_W];
endmodule

### src/psta_ctrl.sv
// Controller state machine sequencing the datapath for one term.
// Depends on psta_pkg.
`timescale 1ns / 1ps
module psta_ctrl
    import psta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PINIT = 11'b00000000010,
        S_PTEST = 11'b00000000100,
        S_MLS   = 11'b00000001000,
        S_ML    = 11'b00000010000,
        S_SQS   = 11'b00000100000,
        S_SQ    = 11'b00001000000,
        S_CMBS  = 11'b00010000000,
        S_CMB   = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_pw    r_pw, n_pw;
    logic   r_dig, n_dig;     // in S_FIN: 0 accumulate, 1 digit steps
    logic   r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_pw    = r_pw;
        n_dig   = r_dig;
        n_ov    = r_ov;
        o_cmd   = '{op: OP_NONE, pw: r_pw, save_first: 1'b0, mul_first: 1'b0};
        o_in_ready = (r_state == S_IDLE) && !r_ov;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.op = OP_LOAD;
                    n_pw     = PW_FIVE;
                    n_state  = S_PINIT;
                end
            end
            S_PINIT: begin
                if (!i_sts.active) begin
                    n_state = S_FIN;
                    n_dig   = 1'b0;
                end else begin
                    o_cmd.op = OP_POW_INIT;
                    n_state  = S_PTEST;
                end
            end
            S_PTEST: begin
                if (i_sts.exp_zero) begin
                    o_cmd.op = OP_POW_SHR;
                    if (r_pw == PW_FIVE) begin
                        o_cmd.save_first = 1'b1;
                        n_pw    = i_sts.neg_exp ? PW_HALF : PW_TWO;
                        n_state = S_PINIT;
                    end else begin
                        n_state = S_CMBS;
                    end
                end else if (i_sts.exp_bit) begin
                    n_state = S_MLS;
                end else begin
                    n_state = S_SQS;
                end
            end
            S_MLS: begin
                o_cmd.op = OP_POW_ML; o_cmd.mul_first = 1'b1; n_state = S_ML;
            end
            S_ML: begin
                o_cmd.op = OP_POW_ML;
                if (i_sts.mm_done) n_state = S_SQS;
            end
            S_SQS: begin
                o_cmd.op = OP_POW_SQ; o_cmd.mul_first = 1'b1; n_state = S_SQ;
            end
            // Square done: exponent shifted, test again
            S_SQ: begin
                o_cmd.op = OP_POW_SQ;
                if (i_sts.mm_done) n_state = S_PTEST;
            end
            S_CMBS: begin
                o_cmd.op = OP_COMBINE; o_cmd.mul_first = 1'b1; n_state = S_CMB;
            end
            S_CMB: begin
                o_cmd.op = OP_COMBINE;
                if (i_sts.mm_done) n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                    n_dig   = 1'b0;
                end
            end
            S_FIN: begin
                if (!r_dig) begin
                    o_cmd.op = OP_ACCUM;
                    n_dig    = 1'b1;
                end else begin
                    o_cmd.op = OP_DIGITS;
                    if (i_sts.dig_done) begin
                        n_state = S_IDLE;
                        n_ov    = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pw    <= PW_FIVE;
            r_dig   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pw    <= n_pw;
            r_dig   <= n_dig;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;

    // Never accept a request while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !o_in_ready) else $error("accept while result pending");
    // Result raised only on leaving the digit phase
    a_ov_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_FIN)) else $error("spurious result");
    // Busy controller holds ready low
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
endmodule

### verif/psta_tb_types.sv
// Request and result layouts used by the accumulator testbench.
// Depends on psta_pkg for field widths.
`timescale 1ns / 1ps
package psta_tb_types;
    import psta_pkg::*;

    typedef struct packed {
        logic                    restart;
        logic                    negate;
        logic signed [EXP_W-1:0] two_exp;
        logic [MOD_W-1:0]        modulus;
    } term_req_t;

    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic [TOP_W-1:0] acc_top;
    } acc_view_t;
endpackage

### verif/tb_pi_series_term_accumulator.sv
// Self-checking bench for pi_series_term_accumulator: drives series terms, predicts
// the 192-bit accumulator and checks every digits/acc_top result in order.
// Depends on psta_pkg, psta_if, psta_tb_types and the RTL.
`timescale 1ns / 1ps
module tb_pi_series_term_accumulator;
    import psta_pkg::*;
    import psta_tb_types::*;

    localparam int  TERM_W    = $bits(term_req_t);
    localparam int  VIEW_W    = $bits(acc_view_t);
    localparam int  CYCLE_CAP = 6000000;
    localparam int  HOLD_LEN  = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    psta_if #(.W(TERM_W)) term_ch ();
    psta_if #(.W(VIEW_W)) view_ch ();

    pi_series_term_accumulator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (term_ch),
        .out_ch     (view_ch)
    );

    // Predictor state and configuration copy
    logic [191:0]      acc_model;
    logic [FIVE_W-1:0] five_exp_model;
    logic [EXP_W-1:0]  cutoff_model;

    term_req_t term_q[$];
    acc_view_t view_exp_q[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  hold_left;
    logic term_taken;
    int  n_fail;
    int  n_terms;
    int  n_views;
    longint cycles;

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] mod_mult(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] base, logic [EXP_W-1:0] ex,
                                              logic [63:0] m);
        logic [63:0] r;
        logic [63:0] b;
        logic [EXP_W-1:0] e;
        r = 64'd1;
        b = base % m;
        e = ex;
        while (e != 0) begin
            if (e[0])
                r = mod_mult(r, b, m);
            b = mod_mult(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // Apply one term to the accumulator copy and return the view it leaves
    function automatic acc_view_t apply_term(term_req_t t);
        logic [63:0]      mu;
        logic [63:0]      r;
        logic [63:0]      half;
        logic [EXP_W-1:0] mag;
        logic [255:0]     quo;
        logic [255:0]     prod;
        acc_view_t        v;
        mu = t.modulus;
        r  = 64'd0;
        if (t.restart)
            acc_model = '0;
        if (mu >= 64'd2) begin
            if (!t.two_exp[EXP_W-1]) begin
                r = mod_mult(mod_power(64'd2, t.two_exp, mu),
                             mod_power(64'd5, EXP_W'(five_exp_model), mu), mu);
            end else begin
                mag = -t.two_exp;
                if (mag < cutoff_model) begin
                    half = (mu >> 1) + {63'd0, mu[0]};
                    r = mod_mult(mod_power(64'd5, EXP_W'(five_exp_model), mu),
                                 mod_power(half, mag, mu), mu);
                end
            end
        end
        if (r != 64'd0) begin
            quo = {r, 192'd0} / {192'd0, mu};
            if (t.negate)
                acc_model = acc_model - quo[191:0];
            else
                acc_model = acc_model + quo[191:0];
        end
        prod      = {64'd0, acc_model} * 256'd1000000000000;
        v.digits  = prod[231:192];
        v.acc_top = acc_model[191:128];
        return v;
    endfunction

    // Mostly well-formed terms, the rest noise: even/zero/one moduli, wide exponents
    function automatic term_req_t random_term();
        term_req_t t;
        int kind;
        kind      = $urandom_range(99);
        t.restart = ($urandom_range(9) == 0);
        t.negate  = $urandom_range(1);
        if (kind < 80) begin
            if ($urandom_range(3) == 0)
                t.modulus = {32'd0, 32'($urandom_range(1000, 3))} | 64'd1;
            else
                t.modulus = {$urandom, $urandom} | 64'd1;
            if ($urandom_range(9) < 6)
                t.two_exp = EXP_W'($urandom_range(64));
            else
                t.two_exp = -EXP_W'($urandom_range(80, 1));
        end else begin
            case ($urandom_range(2))
                0: t.modulus = {$urandom, $urandom} & ~64'd1;
                1: t.modulus = 64'd1;
                default: t.modulus = 64'd0;
            endcase
            if ($urandom_range(3) == 0)
                t.modulus = {$urandom, $urandom};
            t.two_exp = {3'($urandom), $urandom};
            if (!t.two_exp[EXP_W-1] && t.two_exp > 35'sd8589934592)
                t.two_exp = 35'sd8589934592;
        end
        return t;
    endfunction

    function automatic term_req_t mk_term(logic rs, logic ng, logic signed [EXP_W-1:0] e,
                                          logic [63:0] mu);
        term_req_t t;
        t.restart = rs;
        t.negate  = ng;
        t.two_exp = e;
        t.modulus = mu;
        return t;
    endfunction

    // Append a term to the sender's queue
    task automatic queue_term(term_req_t t);
        term_q.insert(term_q.size(), t);
    endtask

    // Sender: advance to the next request once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            term_ch.valid <= 1'b0;
        end else if (!term_ch.valid || term_taken) begin
            if (term_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                term_ch.data  <= term_q.pop_front();
                term_ch.valid <= 1'b1;
            end else begin
                term_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            view_ch.ready <= 1'b0;
        end else begin
            view_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on each accepted term, check each accepted result
    always @(posedge i_clk) begin
        acc_view_t got;
        acc_view_t want;
        cycles++;
        term_taken <= term_ch.valid && term_ch.ready && i_rst_n;
        if (i_rst_n) begin
            if (term_ch.valid && term_ch.ready) begin
                view_exp_q.insert(view_exp_q.size(),
                                  apply_term(term_req_t'(term_ch.data)));
                n_terms++;
            end
            if (view_ch.valid && view_ch.ready) begin
                got = acc_view_t'(view_ch.data);
                n_views++;
                if (view_exp_q.size() == 0) begin
                    $display("%0t: unexpected result digits=%0d acc_top=%h",
                             $time, got.digits, got.acc_top);
                    n_fail++;
                end else begin
                    want = view_exp_q.pop_front();
                    if (got.digits !== want.digits) begin
                        $display("%0t: digits mismatch, expected %0d, got %0d",
                                 $time, want.digits, got.digits);
                        n_fail++;
                    end
                    if (got.acc_top !== want.acc_top) begin
                        $display("%0t: acc_top mismatch, expected %h, got %h",
                                 $time, want.acc_top, got.acc_top);
                        n_fail++;
                    end
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, view_exp_q.size());
            $display("[pi_series_term_accumulator] ERROR");
            $finish;
        end
    end

    // Wait until the block has drained every request and result
    task automatic drain();
        while (term_q.size() > 0 || term_ch.valid || view_exp_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_FIVE_POWER)
            five_exp_model = val[FIVE_W-1:0];
        else
            cutoff_model = val[EXP_W-1:0];
    endtask

    task automatic random_phase(int idle, int stall, int count, bit long_hold);
        drain();
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (long_hold)
            hold_req = 1'b1;
        repeat (count) queue_term(random_term());
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_FIVE_POWER;
        i_cfg_data     = '0;
        term_ch.valid  = 1'b0;
        term_ch.data   = '0;
        view_ch.ready  = 1'b0;
        term_taken     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        n_fail         = 0;
        n_terms        = 0;
        n_views        = 0;
        cycles         = 0;
        acc_model      = '0;
        five_exp_model = FIVE_POWER_RST;
        cutoff_model   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: trivial moduli, extremes, dropped negative exponent, wrap
        queue_term(mk_term(1'b0, 1'b1, 35'sd3, 64'd7));
        queue_term(mk_term(1'b0, 1'b0, 35'sd0, 64'd1));
        queue_term(mk_term(1'b0, 1'b0, 35'sd5, 64'd0));
        queue_term(mk_term(1'b0, 1'b0, 35'sd0, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_term(mk_term(1'b0, 1'b0, 35'sd8589934592, 64'd3));
        queue_term(mk_term(1'b0, 1'b1, -35'sd1, 64'd9));
        queue_term(mk_term(1'b0, 1'b0, 35'sd7, 64'd10));
        queue_term(mk_term(1'b1, 1'b1, 35'sd1, 64'd5));
        queue_term(mk_term(1'b1, 1'b0, 35'sd0, 64'd2));
        queue_term(mk_term(1'b0, 1'b0, 35'sd2, 64'd5));

        // Widest cutoff, zero power of five: deepest negative exponents
        drain();
        write_reg(CFG_FIVE_POWER, '0);
        write_reg(CFG_BAND_CUTOFF, 35'h7_FFFF_FFFF);
        queue_term(mk_term(1'b1, 1'b0, -35'sd1, 64'd11));
        queue_term(mk_term(1'b0, 1'b1, -35'sd17179869184, 64'h8000_0000_0000_0001));
        queue_term(mk_term(1'b0, 1'b0, -35'sd3, 64'd12));
        queue_term(mk_term(1'b0, 1'b1, 35'sd64, 64'hFFFF_FFFF_FFFF_FFFF));

        // Largest power of five, cutoff exactly at the boundary
        drain();
        write_reg(CFG_FIVE_POWER, 35'h0_FFFF_FFFF);
        write_reg(CFG_BAND_CUTOFF, 35'd5);
        queue_term(mk_term(1'b0, 1'b0, -35'sd5, 64'd13));
        queue_term(mk_term(1'b0, 1'b0, -35'sd4, 64'd13));
        queue_term(mk_term(1'b0, 1'b1, 35'sd1, 64'hDEAD_BEEF_0123_4567));
        queue_term(mk_term(1'b1, 1'b1, 35'sd0, 64'd3));

        // Random part across idling modes and settings
        drain();
        write_reg(CFG_FIVE_POWER, 35'($urandom_range(999999)));
        write_reg(CFG_BAND_CUTOFF, 35'd64);
        random_phase(0, 0, 25, 1'b0);
        drain();
        write_reg(CFG_FIVE_POWER, 35'd999999);
        random_phase(76, 0, 25, 1'b0);
        drain();
        write_reg(CFG_BAND_CUTOFF, 35'd100);
        random_phase(0, 76, 25, 1'b1);
        drain();
        write_reg(CFG_FIVE_POWER, 35'($urandom));
        write_reg(CFG_BAND_CUTOFF, 35'd40);
        random_phase(16, 16, 25, 1'b0);
        drain();

        $display("Covered %0d terms and %0d results over reset, extreme and random settings,",
                 n_terms, n_views);
        $display("with sender gaps, receiver stalls and one long receiver hold-off.");
        if (n_fail == 0) begin
            $display("[pi_series_term_accumulator] OK");
        end else begin
            $display("[pi_series_term_accumulator] ERROR");
        end
        $finish;
    end
endmodule
